// ===== rtl/tamc_pkg.sv =====
// Shared types and constants for the temperature alarm mode controller.
// No dependencies; imported by every module of the block.
package tamc_pkg;

    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_MON       = 3'd1;
    localparam logic [2:0] MODE_EDIT_LOW  = 3'd2;
    localparam logic [2:0] MODE_EDIT_HIGH = 3'd3;
    localparam logic [2:0] MODE_ALERT     = 3'd4;

    localparam logic [1:0] BTN_UP   = 2'd0;
    localparam logic [1:0] BTN_DOWN = 2'd1;
    localparam logic [1:0] BTN_MODE = 2'd2;

    localparam logic [0:0] OP_BUTTON = 1'b0;
    localparam logic [0:0] OP_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_SENSOR_MIN = 2'd0;
    localparam logic [1:0] CFG_SENSOR_MAX = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd2;
    localparam logic [1:0] CFG_HOLD       = 2'd3;

    localparam logic signed [7:0] SENSOR_MIN_RST = 8'sd0;
    localparam logic signed [7:0] SENSOR_MAX_RST = 8'sd50;
    localparam logic [31:0]       DEBOUNCE_RST   = 32'd50000;
    localparam logic [31:0]       HOLD_RST       = 32'd1000000;

    typedef struct packed {
        logic [0:0]         op;
        logic [1:0]         button;
        logic               level;
        logic [31:0]        time_us;
        logic signed [11:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [7:0] low_out;
        logic signed [7:0] high_out;
        logic              beep;
        logic              accepted;
    } t_out_item;

    typedef struct packed {
        logic signed [7:0] sensor_min;
        logic signed [7:0] sensor_max;
        logic [31:0]       debounce_us;
        logic [31:0]       hold_us;
    } t_cfg;

    typedef struct packed {
        logic               is_sample;
        logic               accepted;
        logic [1:0]         button;
        logic               pressed;
        logic [31:0]        time_us;
        logic signed [11:0] temperature;
    } t_cmd;

endpackage

// ===== rtl/temperature_alarm_mode_controller_unit.sv =====
// Top level of the temperature alarm mode controller: configuration registers
// and the front end, command queue and back end. Depends on tamc_pkg.
//
// Takes button events and temperature samples and returns one result per item.
// Throughput is one item per clock while the output is not stalled. When its item
// is transferred, the front end writes the command into the two-entry queue; the back
// end then pops it into the output register, where its result is presented, and an
// output stall can hold it in the queue. The back end updates its state as it pops.
// Either side may stall on its own: the queue keeps accepting while a result
// waits, until it holds two commands. Write configuration only while no item is in flight.
module temperature_alarm_mode_controller_unit import tamc_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_min  <= SENSOR_MIN_RST;
            r_cfg.sensor_max  <= SENSOR_MAX_RST;
            r_cfg.debounce_us <= DEBOUNCE_RST;
            r_cfg.hold_us     <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_MIN: r_cfg.sensor_min  <= i_cfg_data[7:0];
                CFG_SENSOR_MAX: r_cfg.sensor_max  <= i_cfg_data[7:0];
                CFG_DEBOUNCE:   r_cfg.debounce_us <= i_cfg_data;
                CFG_HOLD:       r_cfg.hold_us     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    tamc_front #(
        .TIME_BITS(TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_debounce_us(r_cfg.debounce_us),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_cmd        (push_cmd)
    );

    tamc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_cmd  (pop_cmd)
    );

    tamc_back #(
        .TIME_BITS(TIME_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd_valid(q_valid),
        .i_cmd      (pop_cmd),
        .o_cmd_pop  (q_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/tamc_front.sv =====
// Front end: accepts input items, runs the debounce check, pushes commands.
// Depends on tamc_pkg; feeds tamc_queue.
module tamc_front import tamc_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    input  logic [31:0] i_debounce_us,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] gap;
    logic                 is_button;

    assign now_t      = TIME_BITS'(i_in.time_us);
    assign gap        = now_t - r_last;
    assign is_button  = (i_in.op == OP_BUTTON);
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.is_sample   = (i_in.op == OP_SAMPLE);
        o_cmd.accepted    = is_button && (CW'(gap) > CW'(i_debounce_us));
        o_cmd.button      = i_in.button;
        o_cmd.pressed     = i_in.level;
        o_cmd.time_us     = i_in.time_us;
        o_cmd.temperature = i_in.temperature;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (o_push && is_button) begin
            r_last <= now_t;
        end
    end

endmodule

// ===== rtl/tamc_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on tamc_pkg for the command type.
module tamc_queue import tamc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/tamc_back.sv =====
// Back end: held flags, limit editing, mode control and alarm check.
// Depends on tamc_pkg; drains tamc_queue into the output register.
module tamc_back import tamc_pkg::*; #(
    parameter int TIME_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [2:0]           r_mode;
    logic signed [7:0]    r_low;
    logic signed [7:0]    r_high;
    logic                 r_up;
    logic                 r_down;
    logic [TIME_BITS-1:0] r_press;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [2:0]           n_mode;
    logic signed [7:0]    n_low;
    logic signed [7:0]    n_high;
    logic                 n_up;
    logic                 n_down;
    logic [TIME_BITS-1:0] n_press;
    t_out_item            n_out;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] press_gap;
    logic signed [12:0]   temp_e;
    logic signed [12:0]   low_e;
    logic signed [12:0]   high_e;
    logic signed [12:0]   low10;
    logic signed [12:0]   high10;

    function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
        logic signed [7:0] r;
        if (v > 10'sd127) begin
            r = 8'sd127;
        end else if (v < -10'sd128) begin
            r = -8'sd128;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] next_mode(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODE_IDLE:     r = MODE_EDIT_LOW;
            MODE_EDIT_LOW: r = MODE_EDIT_HIGH;
            default:       r = MODE_IDLE;
        endcase
        return r;
    endfunction

    assign o_cmd_pop   = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign now_t     = TIME_BITS'(i_cmd.time_us);
    assign press_gap = now_t - r_press;
    assign temp_e    = 13'(i_cmd.temperature);
    assign low_e     = 13'(r_low);
    assign high_e    = 13'(r_high);
    assign low10     = (low_e <<< 3) + (low_e <<< 1);
    assign high10    = (high_e <<< 3) + (high_e <<< 1);

    always_comb begin
        logic signed [9:0] v;
        logic signed [9:0] lo_v;
        logic signed [9:0] hi_v;
        logic              beep;

        n_mode  = r_mode;
        n_low   = r_low;
        n_high  = r_high;
        n_up    = r_up;
        n_down  = r_down;
        n_press = r_press;
        beep    = 1'b0;
        v       = '0;
        lo_v    = '0;
        hi_v    = '0;

        if (!i_cmd.is_sample) begin
            if (i_cmd.accepted) begin
                case (i_cmd.button)
                    BTN_UP:   n_up = i_cmd.pressed;
                    BTN_DOWN: n_down = i_cmd.pressed;
                    default:  ;
                endcase

                if (n_up) begin
                    lo_v = 10'(n_low);
                    hi_v = 10'(n_high);
                    if (r_mode == MODE_EDIT_LOW) begin
                        v = lo_v + 10'sd1;
                        if (v >= hi_v) begin
                            v = hi_v - 10'sd1;
                        end
                        n_low = sat8(v);
                    end else if (r_mode == MODE_EDIT_HIGH) begin
                        v = hi_v + 10'sd1;
                        if (v > 10'(i_cfg.sensor_max)) begin
                            v = 10'(i_cfg.sensor_max);
                        end
                        n_high = sat8(v);
                    end
                end

                if (n_down) begin
                    lo_v = 10'(n_low);
                    hi_v = 10'(n_high);
                    if (r_mode == MODE_EDIT_LOW) begin
                        v = lo_v - 10'sd1;
                        if (v < 10'(i_cfg.sensor_min)) begin
                            v = 10'(i_cfg.sensor_min);
                        end
                        n_low = sat8(v);
                    end else if (r_mode == MODE_EDIT_HIGH) begin
                        v = hi_v - 10'sd1;
                        if (v <= lo_v) begin
                            v = lo_v + 10'sd1;
                        end
                        n_high = sat8(v);
                    end
                end

                if (i_cmd.button == BTN_MODE) begin
                    if (i_cmd.pressed) begin
                        n_press = now_t;
                        n_mode  = next_mode(r_mode);
                    end else if (CW'(press_gap) > CW'(i_cfg.hold_us)) begin
                        n_mode = MODE_MON;
                    end
                end
            end
        end else begin
            if (r_mode == MODE_ALERT) begin
                beep = 1'b1;
            end else if (r_mode == MODE_MON) begin
                if (temp_e >= high10 || temp_e <= low10) begin
                    n_mode = MODE_ALERT;
                    beep   = 1'b1;
                end
            end
        end

        n_out.mode     = n_mode;
        n_out.low_out  = n_low;
        n_out.high_out = n_high;
        n_out.beep     = beep;
        n_out.accepted = !i_cmd.is_sample && i_cmd.accepted;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_low       <= SENSOR_MIN_RST;
            r_high      <= SENSOR_MAX_RST;
            r_up        <= 1'b0;
            r_down      <= 1'b0;
            r_press     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_mode      <= n_mode;
            r_low       <= n_low;
            r_high      <= n_high;
            r_up        <= n_up;
            r_down      <= n_down;
            r_press     <= n_press;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/tamc_chk.sv =====
// Port-level checker for temperature_alarm_mode_controller_unit, bound below.
// Depends on tamc_pkg for types and mode codes.
module tamc_chk import tamc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [1:0]  i_cfg_idx,
    input logic [31:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input item changed while stalled");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !i_in_valid && !o_out_valid && !$isunknown({i_cfg_idx, i_cfg_data}))
        else $error("register write while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_beep_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.beep |-> o_out.mode == MODE_ALERT)
        else $error("beep outside alerting");

    a_beep_xor_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.beep && o_out.accepted))
        else $error("beep and accepted on one result");

endmodule

bind temperature_alarm_mode_controller_unit tamc_chk u_tamc_chk (.*);

// ===== bench/temperature_alarm_mode_controller_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for temperature_alarm_mode_controller_unit: queue-fed driver,
// checking monitor, item-level model of the controller. Depends on tamc_pkg.
module temperature_alarm_mode_controller_unit_tb;
    import tamc_pkg::*;

    localparam logic [1:0] BTN_SPARE   = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         N_PHASES    = 6;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = CFG_SENSOR_MIN;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;

    temperature_alarm_mode_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    logic signed [7:0] ph_min  [N_PHASES] = '{-128, 10, 127, -128, -50, 127};
    logic signed [7:0] ph_max  [N_PHASES] = '{127, 20, -128, 127, 100, -128};
    logic [31:0]       ph_deb  [N_PHASES] = '{0, 1000, 32'hFFFF_FFFF, 1, 30, 5};
    logic [31:0]       ph_hold [N_PHASES] = '{0, 5000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 200, 10};
    int                ph_len  [N_PHASES] = '{250, 250, 40, 250, 250, 200};
    int                ph_idle [N_PHASES] = '{33, 0, 33, 33, 33, 33};

    // controller model: configuration copy and state
    logic signed [7:0] lim_min, lim_max;
    logic [31:0]       debounce_cfg, hold_cfg;
    logic [2:0]        pm_mode;
    logic signed [7:0] pm_low, pm_high;
    logic              up_held, down_held;
    logic [31:0]       last_evt_us, press_us;

    t_in_item  item_backlog [$];
    t_out_item status_due_q [$];

    logic [31:0] stamp_us;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int n_queued      = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_beeps       = 0;
    int n_taken       = 0;
    int n_settings    = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [7:0] clip8(int v);
        if (v > 127) v = 127;
        else if (v < -128) v = -128;
        return 8'(v);
    endfunction

    function automatic t_out_item panel_step(t_in_item it);
        t_out_item r;
        logic [31:0] gap;
        int v;
        int t;
        r = '0;
        if (it.op == OP_BUTTON) begin
            gap = it.time_us - last_evt_us;
            last_evt_us = it.time_us;
            if (gap > debounce_cfg) begin
                r.accepted = 1'b1;
                if (it.button == BTN_UP) up_held = it.level;
                else if (it.button == BTN_DOWN) down_held = it.level;
                if (up_held) begin
                    if (pm_mode == MODE_EDIT_LOW) begin
                        v = int'(pm_low) + 1;
                        if (v >= int'(pm_high)) v = int'(pm_high) - 1;
                        pm_low = clip8(v);
                    end else if (pm_mode == MODE_EDIT_HIGH) begin
                        v = int'(pm_high) + 1;
                        if (v > int'(lim_max)) v = int'(lim_max);
                        pm_high = clip8(v);
                    end
                end
                if (down_held) begin
                    if (pm_mode == MODE_EDIT_LOW) begin
                        v = int'(pm_low) - 1;
                        if (v < int'(lim_min)) v = int'(lim_min);
                        pm_low = clip8(v);
                    end else if (pm_mode == MODE_EDIT_HIGH) begin
                        v = int'(pm_high) - 1;
                        if (v <= int'(pm_low)) v = int'(pm_low) + 1;
                        pm_high = clip8(v);
                    end
                end
                if (it.button == BTN_MODE) begin
                    gap = it.time_us - press_us;
                    if (it.level) begin
                        press_us = it.time_us;
                        case (pm_mode)
                            MODE_IDLE:     pm_mode = MODE_EDIT_LOW;
                            MODE_EDIT_LOW: pm_mode = MODE_EDIT_HIGH;
                            default:       pm_mode = MODE_IDLE;
                        endcase
                    end else if (gap > hold_cfg) begin
                        pm_mode = MODE_MON;
                    end
                end
            end
        end else begin
            t = $signed(it.temperature);
            if (pm_mode == MODE_ALERT) begin
                r.beep = 1'b1;
            end else if (pm_mode == MODE_MON &&
                         (t >= 10 * int'(pm_high) || t <= 10 * int'(pm_low))) begin
                pm_mode = MODE_ALERT;
                r.beep = 1'b1;
            end
        end
        r.mode     = pm_mode;
        r.low_out  = pm_low;
        r.high_out = pm_high;
        return r;
    endfunction

    task automatic flag_error(string what);
        n_errors++;
        if (n_errors <= 10) $display("ERROR at %0t: %s", $time, what);
    endtask

    // driver: advance the backlog, predict each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                status_due_q.push_back(panel_step(i_in));
                n_items++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (item_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_in       <= item_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each transfer, hold off twice for a long stretch
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (o_out.beep === 1'b1) n_beeps++;
                if (o_out.accepted === 1'b1) n_taken++;
                if (status_due_q.size() == 0) begin
                    flag_error("result with nothing expected");
                end else begin
                    want = status_due_q.pop_front();
                    if (o_out.mode !== want.mode || o_out.low_out !== want.low_out ||
                        o_out.high_out !== want.high_out || o_out.beep !== want.beep ||
                        o_out.accepted !== want.accepted)
                        flag_error($sformatf(
                            "result %0d exp/got mode %0d/%0d low %0d/%0d high %0d/%0d %s",
                            n_results, want.mode, o_out.mode, want.low_out, o_out.low_out,
                            want.high_out, o_out.high_out,
                            $sformatf("beep %b/%b acc %b/%b", want.beep, o_out.beep,
                                      want.accepted, o_out.accepted)));
                end
                if (n_results == 400 || n_results == 1300) hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_button(logic [1:0] btn, logic lvl, logic [31:0] gap);
        t_in_item it;
        stamp_us       += gap;
        it.op          = OP_BUTTON;
        it.button      = btn;
        it.level       = lvl;
        it.time_us     = stamp_us;
        it.temperature = 12'($urandom);
        item_backlog.push_back(it);
        n_queued++;
    endtask

    task automatic queue_sample(logic signed [11:0] temp);
        t_in_item it;
        it.op          = OP_SAMPLE;
        it.button      = 2'($urandom_range(3, 0));
        it.level       = 1'($urandom_range(1, 0));
        it.time_us     = $urandom;
        it.temperature = temp;
        item_backlog.push_back(it);
        n_queued++;
    endtask

    function automatic logic [31:0] pass_gap();
        case ($urandom_range(9, 0))
            0:       return debounce_cfg;
            1:       return debounce_cfg + 32'd1;
            default: return debounce_cfg + 32'd1 + $urandom_range(5000, 0);
        endcase
    endfunction

    function automatic logic signed [11:0] pick_temp();
        int v;
        case ($urandom_range(3, 0))
            0:       v = 10 * int'(pm_high) + int'($urandom_range(4, 0)) - 2;
            1:       v = 10 * int'(pm_low) + int'($urandom_range(4, 0)) - 2;
            2:       v = int'($urandom_range(1650, 0)) - 400;
            default: v = $urandom;
        endcase
        return 12'(v);
    endfunction

    task automatic queue_scenario();
        int pick;
        int k;
        logic [1:0] btn;
        logic [31:0] gap;
        pick = $urandom_range(99, 0);
        btn  = $urandom_range(1, 0) ? BTN_UP : BTN_DOWN;
        if (pick < 25) begin
            queue_button(BTN_MODE, 1'b1, pass_gap());
            if ($urandom_range(1, 0)) queue_button(BTN_MODE, 1'b1, pass_gap());
            queue_button(btn, 1'b1, pass_gap());
            k = $urandom_range(12, 0);
            repeat (k) queue_button(BTN_SPARE, 1'b1, pass_gap());
            queue_button(btn, 1'b0, pass_gap());
            queue_button(BTN_MODE, 1'b0, pass_gap());
        end else if (pick < 45) begin
            queue_button(BTN_MODE, 1'b1, pass_gap());
            gap = hold_cfg + 32'd1 + $urandom_range(100, 0);
            if (gap <= debounce_cfg) gap = pass_gap();
            queue_button(BTN_MODE, 1'b0, gap);
            k = $urandom_range(6, 1);
            repeat (k) queue_sample(pick_temp());
        end else if (pick < 70) begin
            k = $urandom_range(8, 1);
            repeat (k) queue_sample(pick_temp());
        end else if (pick < 88) begin
            queue_button(btn, 1'b1, pass_gap());
            k = ($urandom_range(9, 0) == 0) ? 150 : $urandom_range(40, 1);
            repeat (k) queue_button($urandom_range(1, 0) ? BTN_SPARE : btn, 1'b1, pass_gap());
            queue_button(btn, 1'b0, pass_gap());
        end else begin
            k = $urandom_range(4, 1);
            repeat (k) begin
                if ($urandom_range(1, 0))
                    queue_sample(12'($urandom));
                else
                    queue_button(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
                                 ($urandom_range(3, 0) == 0) ? $urandom
                                                             : $urandom_range(200, 0));
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SENSOR_MIN: lim_min      = val[7:0];
            CFG_SENSOR_MAX: lim_max      = val[7:0];
            CFG_DEBOUNCE:   debounce_cfg = val;
            default:        hold_cfg     = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic play_phase(int count, int idle_pct);
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        n_queued = 0;
        while (n_queued < count) queue_scenario();
        do @(negedge i_clk);
        while (item_backlog.size() != 0 || i_in_valid || status_due_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        lim_min      = SENSOR_MIN_RST;
        lim_max      = SENSOR_MAX_RST;
        debounce_cfg = DEBOUNCE_RST;
        hold_cfg     = HOLD_RST;
        pm_mode      = MODE_IDLE;
        pm_low       = SENSOR_MIN_RST;
        pm_high      = SENSOR_MAX_RST;
        up_held      = 1'b0;
        down_held    = 1'b0;
        last_evt_us  = '0;
        press_us     = '0;
        stamp_us     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_sample(12'sh7FF);
        queue_sample(12'sh800);
        queue_button(BTN_UP, 1'b1, 32'd0);
        queue_button(BTN_MODE, 1'b1, 32'd100000);
        queue_button(BTN_UP, 1'b1, 32'd100000);
        queue_button(BTN_SPARE, 1'b1, 32'd100000);
        queue_button(BTN_UP, 1'b0, 32'd100000);
        queue_button(BTN_DOWN, 1'b1, 32'd100000);
        queue_button(BTN_DOWN, 1'b1, 32'd20000);
        queue_button(BTN_DOWN, 1'b0, 32'd100000);
        queue_button(BTN_MODE, 1'b0, 32'd100000);
        queue_button(BTN_MODE, 1'b1, 32'd100000);
        queue_button(BTN_UP, 1'b1, 32'd100000);
        queue_button(BTN_UP, 1'b0, 32'd100000);
        queue_button(BTN_DOWN, 1'b1, 32'd100000);
        queue_button(BTN_DOWN, 1'b0, 32'd100000);
        queue_button(BTN_MODE, 1'b0, 32'd2000000);
        queue_sample(12'sd250);
        queue_sample(12'sd490);
        queue_sample(-12'sd400);
        queue_sample(12'sd1250);
        queue_button(BTN_MODE, 1'b1, 32'd100000);
        stamp_us = 32'hFFFF_FF00;
        queue_button(BTN_MODE, 1'b0, 32'h0000_00FF);
        queue_button(BTN_SPARE, 1'b0, 32'd100001);
        queue_sample(12'sd10);
        play_phase(250, 33);

        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_SENSOR_MIN, 32'(ph_min[p]));
            write_reg(CFG_SENSOR_MAX, 32'(ph_max[p]));
            write_reg(CFG_DEBOUNCE, ph_deb[p]);
            write_reg(CFG_HOLD, ph_hold[p]);
            n_settings++;
            @(negedge i_clk);
            play_phase(ph_len[p], ph_idle[p]);
        end

        repeat (8) @(negedge i_clk);
        $display("Ran %0d items under %0d register settings, %0d results checked",
                 n_items, n_settings, n_results);
        $display("Button events taken: %0d, beeps requested: %0d, errors: %0d",
                 n_taken, n_beeps, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== temperature_alarm_mode_controller_unit.f =====
rtl/tamc_pkg.sv
rtl/tamc_front.sv
rtl/tamc_queue.sv
rtl/tamc_back.sv
rtl/temperature_alarm_mode_controller_unit.sv
rtl/tamc_chk.sv
bench/temperature_alarm_mode_controller_unit_tb.sv
